### rtl/pbms_pkg.sv
package pbms_pkg;

	localparam int IDX_W  = 10;
	localparam int RUNS_W = 9;
	localparam int PTS_W  = 11;
	localparam int SUM_W  = 32;
	localparam int SQ_W   = 56;
	localparam int DEN_W  = 2 * RUNS_W;
	localparam int NUM_W  = SQ_W + RUNS_W;
	localparam int VAR_W  = 64;
	localparam int ROOT_W = VAR_W / 2;

	localparam logic [RUNS_W-1:0] RUNS_RESET  = 9'd2;
	localparam logic [PTS_W-1:0]  POINTS_RESET = 11'd1024;

	typedef enum logic [0:0] {
		REG_NUM_RUNS   = 1'b0,
		REG_NUM_POINTS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sq;
	} acc_res_t;

endpackage

### rtl/pbms_ram.sv
module pbms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/pbms_accum.sv
module pbms_accum #(
	parameter int MAX_POINTS  = 1024,
	parameter int SAMPLE_BITS = 24,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  logic [pbms_pkg::IDX_W-1:0]       point_index,
	input  logic signed [SAMPLE_BITS-1:0]    sample,
	input  logic                             final_run,
	output logic                             clearing,
	output logic                             res_valid,
	output pbms_pkg::acc_res_t               res
);

	localparam int SUM_W = pbms_pkg::SUM_W;
	localparam int SQ_W  = pbms_pkg::SQ_W;
	localparam int W     = SUM_W + SQ_W;

	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	logic                          v_s1, last_s1;
	logic [pbms_pkg::IDX_W-1:0]    idx_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [2*SAMPLE_BITS-1:0]      sqr;

	logic                          v_s2, last_s2;
	logic [pbms_pkg::IDX_W-1:0]    idx_s2;
	logic signed [SAMPLE_BITS-1:0] x_s2;
	logic [SQ_W-1:0]               sq_s2;

	logic                          wr_v_q;
	logic [pbms_pkg::IDX_W-1:0]    wr_idx_q;
	logic [SUM_W-1:0]              wr_sum_q;
	logic [SQ_W-1:0]               wr_sq_q;

	logic [W-1:0]     rdata, wdata;
	logic [AW-1:0]    waddr;
	logic             we, hit;
	logic [SUM_W-1:0] base_sum, new_sum;
	logic [SQ_W-1:0]  base_sq, new_sq;

	pbms_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (AW'(idx_s1)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_POINTS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign clearing = clr_q;

	assign mag = x_s1[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_s1) : SAMPLE_BITS'(x_s1);
	assign sqr = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);

	assign hit      = wr_v_q && (wr_idx_q == idx_s2);
	assign base_sum = hit ? wr_sum_q : rdata[SUM_W-1:0];
	assign base_sq  = hit ? wr_sq_q : rdata[W-1:SUM_W];
	assign new_sum  = base_sum + SUM_W'(x_s2);
	assign new_sq   = base_sq + sq_s2;

	always_comb begin
		we    = clr_q || v_s2;
		waddr = clr_q ? clr_addr_q : AW'(idx_s2);
		wdata = (clr_q || last_s2) ? '0 : {new_sq, new_sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			wr_v_q    <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			v_s1      <= take;
			v_s2      <= v_s1;
			wr_v_q    <= v_s2;
			res_valid <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= point_index;
		x_s1     <= sample;
		last_s1  <= final_run;
		idx_s2   <= idx_s1;
		x_s2     <= x_s1;
		last_s2  <= last_s1;
		sq_s2    <= SQ_W'(sqr);
		wr_idx_q <= idx_s2;
		wr_sum_q <= last_s2 ? '0 : new_sum;
		wr_sq_q  <= last_s2 ? '0 : new_sq;
		res.idx  <= idx_s2;
		res.sum  <= $signed(new_sum);
		res.sq   <= new_sq;
	end

endmodule

### rtl/pbms_div.sv
module pbms_div #(
	parameter int NUM_W = 65,
	parameter int DEN_W = 18,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo,
	output logic [TAG_W-1:0] out_tag
);

	logic             v_s   [1:NUM_W];
	logic [DEN_W-1:0] rem_s [1:NUM_W];
	logic [NUM_W-1:0] num_s [1:NUM_W];
	logic [NUM_W-1:0] quo_s [1:NUM_W];
	logic [DEN_W-1:0] den_s [1:NUM_W];
	logic [TAG_W-1:0] tag_s [1:NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic             cv;
		logic [DEN_W-1:0] crem, cden;
		logic [NUM_W-1:0] cnum, cquo;
		logic [TAG_W-1:0] ctag;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign cv   = in_valid;
			assign crem = '0;
			assign cnum = num;
			assign cquo = '0;
			assign cden = den;
			assign ctag = tag;
		end else begin : g_next
			assign cv   = v_s[i];
			assign crem = rem_s[i];
			assign cnum = num_s[i];
			assign cquo = quo_s[i];
			assign cden = den_s[i];
			assign ctag = tag_s[i];
		end

		assign trial = {crem, cnum[NUM_W-1]};
		assign ge    = trial >= {1'b0, cden};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? DEN_W'(trial - {1'b0, cden}) : DEN_W'(trial);
			num_s[i+1] <= cnum << 1;
			quo_s[i+1] <= {cquo[NUM_W-2:0], ge};
			den_s[i+1] <= cden;
			tag_s[i+1] <= ctag;
		end
	end

	assign out_valid = v_s[NUM_W];
	assign quo       = quo_s[NUM_W];
	assign out_tag   = tag_s[NUM_W];

endmodule

### rtl/pbms_sqrt.sv
module pbms_sqrt #(
	parameter int TAG_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [pbms_pkg::VAR_W-1:0]    x,
	input  logic [TAG_W-1:0]              tag,
	output logic                          out_valid,
	output logic [pbms_pkg::ROOT_W-1:0]   root,
	output logic [TAG_W-1:0]              out_tag
);

	localparam int XW = pbms_pkg::VAR_W;
	localparam int N  = pbms_pkg::ROOT_W;

	logic          v_s   [1:N];
	logic [XW-1:0] x_s   [1:N];
	logic [XW-1:0] res_s [1:N];
	logic [TAG_W-1:0] tag_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2 * i);
		logic          cv, ge;
		logic [XW-1:0] cx, cres, t;
		logic [TAG_W-1:0] ctag;

		if (i == 0) begin : g_first
			assign cv   = in_valid;
			assign cx   = x;
			assign cres = '0;
			assign ctag = tag;
		end else begin : g_next
			assign cv   = v_s[i];
			assign cx   = x_s[i];
			assign cres = res_s[i];
			assign ctag = tag_s[i];
		end

		assign t  = cres + BIT;
		assign ge = cx >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			x_s[i+1]   <= ge ? cx - t : cx;
			res_s[i+1] <= ge ? (cres >> 1) + BIT : cres >> 1;
			tag_s[i+1] <= ctag;
		end
	end

	assign out_valid = v_s[N];
	assign root      = res_s[N][N-1:0];
	assign out_tag   = tag_s[N];

endmodule

### rtl/pbms_finish.sv
module pbms_finish #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  pbms_pkg::acc_res_t              in_res,
	input  logic [pbms_pkg::RUNS_W-1:0]     n,
	output logic                            done,
	output logic [pbms_pkg::IDX_W-1:0]      out_index,
	output logic signed [SAMPLE_BITS-1:0]   mean_value,
	output logic signed [SAMPLE_BITS-1:0]   upper_band,
	output logic signed [SAMPLE_BITS-1:0]   lower_band
);

	localparam int IDX_W  = pbms_pkg::IDX_W;
	localparam int RUNS_W = pbms_pkg::RUNS_W;
	localparam int SUM_W  = pbms_pkg::SUM_W;
	localparam int NUM_W  = pbms_pkg::NUM_W;
	localparam int DEN_W  = pbms_pkg::DEN_W;
	localparam int VAR_W  = pbms_pkg::VAR_W;
	localparam int ROOT_W = pbms_pkg::ROOT_W;
	localparam logic signed [35:0] HI = 36'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [35:0] LO = -HI - 36'sd1;

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = (v > HI) ? HI : ((v < LO) ? LO : v);
		return SAMPLE_BITS'(r);
	endfunction

	logic [SUM_W-1:0] mag;

	logic                 v_s1, sign_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [NUM_W-1:0]     pa_s1;
	logic [2*SUM_W-1:0]   pb_s1;
	logic [SUM_W:0]       mnum_s1;
	logic [DEN_W-1:0]     d_s1;
	logic [RUNS_W-1:0]    n_s1;

	logic [NUM_W:0]       diff;

	logic                 v_s2, sign_s2;
	logic [IDX_W-1:0]     idx_s2;
	logic [NUM_W-1:0]     num_s2;
	logic [NUM_W-1:0]     mnum_s2;
	logic [DEN_W-1:0]     d_s2;
	logic [RUNS_W-1:0]    n_s2;

	logic                 vv, mv, msign;
	logic [NUM_W-1:0]     vq, mq;
	logic [IDX_W-1:0]     vidx;
	logic signed [35:0]   m36;

	logic                          v_s3;
	logic [IDX_W-1:0]              idx_s3;
	logic signed [SAMPLE_BITS-1:0] mean_s3;
	logic [VAR_W-1:0]              var_s3;

	logic                          rv;
	logic [ROOT_W-1:0]             root;
	logic [IDX_W+SAMPLE_BITS-1:0]  rtag;
	logic signed [SAMPLE_BITS-1:0] rmean;

	assign mag  = in_res.sum[SUM_W-1] ? SUM_W'(-in_res.sum) : SUM_W'(in_res.sum);
	assign diff = (NUM_W+1)'(pa_s1) - (NUM_W+1)'(pb_s1);

	pbms_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(IDX_W)) u_var_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.num       (num_s2),
		.den       (d_s2),
		.tag       (idx_s2),
		.out_valid (vv),
		.quo       (vq),
		.out_tag   (vidx)
	);

	pbms_div #(.NUM_W(NUM_W), .DEN_W(RUNS_W), .TAG_W(1)) u_mean_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.num       (mnum_s2),
		.den       (n_s2),
		.tag       (sign_s2),
		.out_valid (mv),
		.quo       (mq),
		.out_tag   (msign)
	);

	assign m36 = msign ? -36'(mq[33:0]) : 36'(mq[33:0]);

	pbms_sqrt #(.TAG_W(IDX_W + SAMPLE_BITS)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.x         (var_s3),
		.tag       ({idx_s3, mean_s3}),
		.out_valid (rv),
		.root      (root),
		.out_tag   (rtag)
	);

	assign rmean = $signed(rtag[SAMPLE_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= vv && mv;
			done <= rv;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= in_res.idx;
		sign_s1 <= in_res.sum[SUM_W-1];
		pa_s1   <= NUM_W'(n) * NUM_W'(in_res.sq);
		pb_s1   <= (2*SUM_W)'(mag) * (2*SUM_W)'(mag);
		mnum_s1 <= (SUM_W+1)'(mag) + (SUM_W+1)'(n >> 1);
		d_s1    <= DEN_W'(n) * DEN_W'(n - RUNS_W'(1));
		n_s1    <= n;

		idx_s2  <= idx_s1;
		sign_s2 <= sign_s1;
		num_s2  <= diff[NUM_W] ? '0 : diff[NUM_W-1:0];
		mnum_s2 <= NUM_W'(mnum_s1);
		d_s2    <= d_s1;
		n_s2    <= n_s1;

		idx_s3  <= vidx;
		mean_s3 <= sat(m36);
		var_s3  <= vq[NUM_W-1] ? '1 : vq[VAR_W-1:0];

		out_index  <= rtag[IDX_W+SAMPLE_BITS-1:SAMPLE_BITS];
		mean_value <= rmean;
		upper_band <= sat(36'(rmean) + $signed(36'(root)));
		lower_band <= sat(36'(rmean) - $signed(36'(root)));
	end

endmodule

### rtl/per_bin_mean_stddev.sv
// channel   signals                                          handshake
// sample    start, busy, point_index, sample, final_run      start && !busy
// result    done, out_index, mean_value, upper_band, lower_band  done, one cycle
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB, pready tied high
//
// One sample is taken every cycle while busy is low; the store update is one
// read-modify-write per sample with forwarding of the previous write around the
// registered RAM read. After the final-run sample is taken, its result passes
// through the 65-stage bit-serial dividers running side by side and then the
// 32-stage square root pipeline.
// After reset busy stays high while all MAX_POINTS store entries are cleared.
// The receiver cannot stall: the pipeline never holds.
module per_bin_mean_stddev #(
	parameter int MAX_POINTS  = 1024,
	parameter int MAX_RUNS    = 256,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [pbms_pkg::IDX_W-1:0]         point_index,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic                               final_run,
	output logic                               done,
	output logic [pbms_pkg::IDX_W-1:0]         out_index,
	output logic signed [SAMPLE_BITS-1:0]      mean_value,
	output logic signed [SAMPLE_BITS-1:0]      upper_band,
	output logic signed [SAMPLE_BITS-1:0]      lower_band,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int RUNS_W = pbms_pkg::RUNS_W;
	localparam int PTS_W  = pbms_pkg::PTS_W;

	logic [RUNS_W-1:0]  num_runs_q, n_eff;
	logic [PTS_W-1:0]   num_points_q;
	logic               in_use, take, res_valid;
	pbms_pkg::reg_idx_t sel;
	pbms_pkg::acc_res_t res;

	assign pready = 1'b1;
	assign sel    = pbms_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_runs_q   <= pbms_pkg::RUNS_RESET;
			num_points_q <= pbms_pkg::POINTS_RESET;
		end else if (psel && penable && pwrite) begin
			case (sel)
				pbms_pkg::REG_NUM_RUNS:   num_runs_q <= pwdata[RUNS_W-1:0];
				pbms_pkg::REG_NUM_POINTS: num_points_q <= pwdata[PTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			pbms_pkg::REG_NUM_RUNS:   prdata = 32'(num_runs_q);
			pbms_pkg::REG_NUM_POINTS: prdata = 32'(num_points_q);
			default:                  prdata = '0;
		endcase
	end

	always_comb begin
		if (num_runs_q < RUNS_W'(2)) begin
			n_eff = RUNS_W'(2);
		end else if (18'(num_runs_q) > 18'(MAX_RUNS)) begin
			n_eff = RUNS_W'(MAX_RUNS);
		end else begin
			n_eff = num_runs_q;
		end
	end

	assign in_use = (18'(point_index) < 18'(num_points_q)) &&
	                (18'(point_index) < 18'(MAX_POINTS));
	assign take   = start && !busy && in_use;

	pbms_accum #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.point_index (point_index),
		.sample      (sample),
		.final_run   (final_run),
		.clearing    (busy),
		.res_valid   (res_valid),
		.res         (res)
	);

	pbms_finish #(.SAMPLE_BITS(SAMPLE_BITS)) u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (res_valid),
		.in_res     (res),
		.n          (n_eff),
		.done       (done),
		.out_index  (out_index),
		.mean_value (mean_value),
		.upper_band (upper_band),
		.lower_band (lower_band)
	);

endmodule
